// ===== rtl/nvrs_pkg.sv =====
// Shared types, widths and codes for the NV12 to RGB nearest-neighbor scaler.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package nvrs_pkg;

    // Store depths (powers of two) and the largest source dimension
    localparam int LUMA_WORDS   = 1048576;
    localparam int CHROMA_WORDS = 524288;
    localparam int MAX_DIM      = 1024;

    localparam int LUMA_AW  = $clog2(LUMA_WORDS);
    localparam int CHROMA_AW = $clog2(CHROMA_WORDS);
    localparam int CW_AW    = CHROMA_AW - 1;
    localparam int COORD_W  = $clog2(MAX_DIM);

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 20;
    localparam int BYTE_W   = 8;
    localparam int DEST_W   = 10;
    localparam int DIM_W    = 11;
    localparam int STEP_W   = 26;
    localparam int FRAC_W   = 16;
    localparam int SUM_W    = 21;
    localparam int Q_SHIFT  = 10;

    // APB register map
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LINE_STRIDE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_X_STEP      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_Y_STEP      = 3'd4;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LUMA    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHROMA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONVERT = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0]  src_width;
        logic [DIM_W-1:0]  src_height;
        logic [DIM_W-1:0]  line_stride;
        logic [STEP_W-1:0] x_step;
        logic [STEP_W-1:0] y_step;
    } cfg_t;

    typedef struct packed {
        logic wr_luma;
        logic wr_chroma;
        logic load_map;
        logic load_addr;
        logic read_mem;
        logic load_terms;
        logic load_out;
    } cmd_t;

endpackage

// ===== rtl/nvrs_regs.sv =====
// APB configuration registers for the scaler: geometry and Q10.16 steps.
// Depends on nvrs_pkg.
`timescale 1ns / 1ps

module nvrs_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nvrs_pkg::PADDR_W-1:0]  paddr,
    input  logic [nvrs_pkg::PDATA_W-1:0]  pwdata,
    output logic [nvrs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output nvrs_pkg::cfg_t                cfg
);

    nvrs_pkg::cfg_t                   cfg_reg;
    nvrs_pkg::cfg_t                   cfg_next;
    logic [nvrs_pkg::REG_IDX_W-1:0]   reg_idx;
    logic                             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[nvrs_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                nvrs_pkg::REG_SRC_WIDTH:   cfg_next.src_width   = pwdata[nvrs_pkg::DIM_W-1:0];
                nvrs_pkg::REG_SRC_HEIGHT:  cfg_next.src_height  = pwdata[nvrs_pkg::DIM_W-1:0];
                nvrs_pkg::REG_LINE_STRIDE: cfg_next.line_stride = pwdata[nvrs_pkg::DIM_W-1:0];
                nvrs_pkg::REG_X_STEP:      cfg_next.x_step      = pwdata[nvrs_pkg::STEP_W-1:0];
                nvrs_pkg::REG_Y_STEP:      cfg_next.y_step      = pwdata[nvrs_pkg::STEP_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            nvrs_pkg::REG_SRC_WIDTH:   prdata = nvrs_pkg::PDATA_W'(cfg_reg.src_width);
            nvrs_pkg::REG_SRC_HEIGHT:  prdata = nvrs_pkg::PDATA_W'(cfg_reg.src_height);
            nvrs_pkg::REG_LINE_STRIDE: prdata = nvrs_pkg::PDATA_W'(cfg_reg.line_stride);
            nvrs_pkg::REG_X_STEP:      prdata = nvrs_pkg::PDATA_W'(cfg_reg.x_step);
            nvrs_pkg::REG_Y_STEP:      prdata = nvrs_pkg::PDATA_W'(cfg_reg.y_step);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width   <= 11'd720;
            cfg_reg.src_height  <= 11'd480;
            cfg_reg.line_stride <= 11'd720;
            cfg_reg.x_step      <= 26'd73728;
            cfg_reg.y_step      <= 26'd49152;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/nvrs_ctrl.sv =====
// Controller for the scaler: accepts items, sequences a convert through
// address, fetch, product and sum steps, and owns the result valid flag.
// Depends on nvrs_pkg.
`timescale 1ns / 1ps

module nvrs_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [nvrs_pkg::KIND_W-1:0]  kind,
    output logic                         out_valid,
    input  logic                         out_ready,
    output nvrs_pkg::cmd_t               cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADDR = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_MATH = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.wr_luma   = accept && (kind == nvrs_pkg::KIND_LUMA);
                cmd.wr_chroma = accept && (kind == nvrs_pkg::KIND_CHROMA);
                cmd.load_map  = accept && (kind == nvrs_pkg::KIND_CONVERT);
                if (cmd.load_map)
                    state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.load_addr = 1'b1;
                state_next    = S_READ;
            end
            S_READ:
            begin
                cmd.read_mem = 1'b1;
                state_next   = S_MATH;
            end
            S_MATH:
            begin
                cmd.load_terms = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                // hold until the result register is free
                cmd.load_out = out_free;
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/nvrs_datapath.sv =====
// Datapath for the scaler: luma and chroma frame stores, coordinate
// mapping, address generation and the Q10 BT.601 matrix with clamping.
// Depends on nvrs_pkg.
`timescale 1ns / 1ps

module nvrs_datapath (
    input  logic                         clk,
    input  nvrs_pkg::cmd_t               cmd,
    input  nvrs_pkg::cfg_t               cfg,
    input  logic [nvrs_pkg::ADDR_W-1:0]  store_address,
    input  logic [nvrs_pkg::BYTE_W-1:0]  store_value,
    input  logic [nvrs_pkg::DEST_W-1:0]  dest_x,
    input  logic [nvrs_pkg::DEST_W-1:0]  dest_y,
    output logic [nvrs_pkg::BYTE_W-1:0]  red,
    output logic [nvrs_pkg::BYTE_W-1:0]  green,
    output logic [nvrs_pkg::BYTE_W-1:0]  blue
);

    localparam int PROD_W   = nvrs_pkg::DEST_W + nvrs_pkg::STEP_W;
    localparam int SCALED_W = PROD_W - nvrs_pkg::FRAC_W;
    localparam int LIN_W    = nvrs_pkg::COORD_W + nvrs_pkg::DIM_W + 1;
    localparam int SW       = nvrs_pkg::SUM_W;

    localparam logic signed [SW-1:0] C_Y  = 21'sd1192;
    localparam logic signed [SW-1:0] C_RV = 21'sd1634;
    localparam logic signed [SW-1:0] C_GV = 21'sd833;
    localparam logic signed [SW-1:0] C_GU = 21'sd400;
    localparam logic signed [SW-1:0] C_BU = 21'sd2066;

    logic [nvrs_pkg::BYTE_W-1:0] luma_mem   [nvrs_pkg::LUMA_WORDS];
    logic [nvrs_pkg::BYTE_W-1:0] chroma_u_mem [nvrs_pkg::CHROMA_WORDS/2];
    logic [nvrs_pkg::BYTE_W-1:0] chroma_v_mem [nvrs_pkg::CHROMA_WORDS/2];

    logic [nvrs_pkg::COORD_W-1:0] sx_reg;
    logic [nvrs_pkg::COORD_W-1:0] sy_reg;
    logic [nvrs_pkg::COORD_W-1:0] sx_next;
    logic [nvrs_pkg::COORD_W-1:0] sy_next;
    logic [nvrs_pkg::LUMA_AW-1:0] luma_addr_reg;
    logic [nvrs_pkg::LUMA_AW-1:0] luma_addr_next;
    logic [nvrs_pkg::CW_AW-1:0]   cw_addr_reg;
    logic [nvrs_pkg::CW_AW-1:0]   cw_addr_next;
    logic [LIN_W-1:0]             luma_lin;
    logic [LIN_W-1:0]             cw_lin;
    logic [nvrs_pkg::BYTE_W-1:0]  luma_rd_reg;
    logic [nvrs_pkg::BYTE_W-1:0]  u_rd_reg;
    logic [nvrs_pkg::BYTE_W-1:0]  v_rd_reg;

    logic                         luma_in_range;
    logic                         chroma_in_range;

    logic signed [8:0]            y_s;
    logic signed [7:0]            u_s;
    logic signed [7:0]            v_s;
    logic signed [SW-1:0]         term_y_reg;
    logic signed [SW-1:0]         term_rv_reg;
    logic signed [SW-1:0]         term_gv_reg;
    logic signed [SW-1:0]         term_gu_reg;
    logic signed [SW-1:0]         term_bu_reg;
    logic signed [SW-1:0]         term_y_next;
    logic signed [SW-1:0]         term_rv_next;
    logic signed [SW-1:0]         term_gv_next;
    logic signed [SW-1:0]         term_gu_next;
    logic signed [SW-1:0]         term_bu_next;
    logic signed [SW-1:0]         sum_r;
    logic signed [SW-1:0]         sum_g;
    logic signed [SW-1:0]         sum_b;

    logic [nvrs_pkg::BYTE_W-1:0]  red_reg;
    logic [nvrs_pkg::BYTE_W-1:0]  green_reg;
    logic [nvrs_pkg::BYTE_W-1:0]  blue_reg;

    function automatic logic [nvrs_pkg::COORD_W-1:0] map_coord(
        input logic [nvrs_pkg::DEST_W-1:0] d,
        input logic [nvrs_pkg::STEP_W-1:0] step,
        input logic [nvrs_pkg::DIM_W-1:0]  size
    );
        logic [PROD_W-1:0]            product;
        logic [SCALED_W-1:0]          scaled;
        logic [31:0]                  lim;
        logic [nvrs_pkg::COORD_W-1:0] bound;
        product = PROD_W'(d) * PROD_W'(step);
        scaled  = product[PROD_W-1:nvrs_pkg::FRAC_W];
        lim     = (32'(size) > 32'(nvrs_pkg::MAX_DIM)) ? 32'(nvrs_pkg::MAX_DIM) : 32'(size);
        bound   = (lim == 32'd0) ? '0 : nvrs_pkg::COORD_W'(lim - 32'd1);
        if (scaled > SCALED_W'(bound))
            return bound;
        else
            return nvrs_pkg::COORD_W'(scaled);
    endfunction

    function automatic logic [nvrs_pkg::BYTE_W-1:0] sat_channel(
        input logic signed [SW-1:0] s
    );
        logic [SW-nvrs_pkg::Q_SHIFT-1:0] q;
        q = s[SW-1:nvrs_pkg::Q_SHIFT];
        if (s[SW-1])
            return '0;
        else if (q > (SW - nvrs_pkg::Q_SHIFT)'(255))
            return 8'd255;
        else
            return q[nvrs_pkg::BYTE_W-1:0];
    endfunction

    // store writes
    assign luma_in_range   = (32'(store_address) < 32'(nvrs_pkg::LUMA_WORDS));
    assign chroma_in_range = (32'(store_address) < 32'(nvrs_pkg::CHROMA_WORDS));

    always_ff @(posedge clk)
    begin
        if (cmd.wr_luma && luma_in_range)
            luma_mem[nvrs_pkg::LUMA_AW'(store_address)] <= store_value;
        if (cmd.wr_chroma && chroma_in_range && !store_address[0])
            chroma_u_mem[nvrs_pkg::CW_AW'(store_address >> 1)] <= store_value;
        if (cmd.wr_chroma && chroma_in_range && store_address[0])
            chroma_v_mem[nvrs_pkg::CW_AW'(store_address >> 1)] <= store_value;
    end

    // coordinate mapping and addresses
    assign sx_next = map_coord(dest_x, cfg.x_step, cfg.src_width);
    assign sy_next = map_coord(dest_y, cfg.y_step, cfg.src_height);

    assign luma_lin = LIN_W'(sy_reg) * LIN_W'(cfg.line_stride) + LIN_W'(sx_reg);
    assign cw_lin   = LIN_W'(sy_reg >> 1) * LIN_W'(cfg.line_stride >> 1) + LIN_W'(sx_reg >> 1);
    assign luma_addr_next = nvrs_pkg::LUMA_AW'(luma_lin);
    assign cw_addr_next   = nvrs_pkg::CW_AW'(cw_lin);

    // matrix products
    assign y_s = $signed({1'b0, luma_rd_reg}) - 9'sd16;
    assign u_s = $signed({~u_rd_reg[7], u_rd_reg[6:0]});
    assign v_s = $signed({~v_rd_reg[7], v_rd_reg[6:0]});

    assign term_y_next  = C_Y  * SW'(y_s);
    assign term_rv_next = C_RV * SW'(v_s);
    assign term_gv_next = C_GV * SW'(v_s);
    assign term_gu_next = C_GU * SW'(u_s);
    assign term_bu_next = C_BU * SW'(u_s);

    assign sum_r = term_y_reg + term_rv_reg;
    assign sum_g = term_y_reg - term_gv_reg - term_gu_reg;
    assign sum_b = term_y_reg + term_bu_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_map)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
        if (cmd.load_addr)
        begin
            luma_addr_reg <= luma_addr_next;
            cw_addr_reg   <= cw_addr_next;
        end
        if (cmd.read_mem)
        begin
            luma_rd_reg <= luma_mem[luma_addr_reg];
            u_rd_reg    <= chroma_u_mem[cw_addr_reg];
            v_rd_reg    <= chroma_v_mem[cw_addr_reg];
        end
        if (cmd.load_terms)
        begin
            term_y_reg  <= term_y_next;
            term_rv_reg <= term_rv_next;
            term_gv_reg <= term_gv_next;
            term_gu_reg <= term_gu_next;
            term_bu_reg <= term_bu_next;
        end
        if (cmd.load_out)
        begin
            red_reg   <= sat_channel(sum_r);
            green_reg <= sat_channel(sum_g);
            blue_reg  <= sat_channel(sum_b);
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// ===== rtl/nv12_to_rgb_nearest_scaler.sv =====
// Top level of the NV12 to RGB nearest-neighbor scaler: register file,
// controller and datapath. Depends on nvrs_pkg, nvrs_regs, nvrs_ctrl, nvrs_datapath.
//
//  channel   direction  transfer when            payload
//  input     in         in_valid & in_ready      kind, store_address, store_value,
//                                                dest_x, dest_y
//  result    out        out_valid & out_ready    red, green, blue
//  config    in         psel&penable&pwrite      paddr, pwdata (prdata on read)
//
// Store writes (kind 0 and 1) and unused kinds are taken in idle and leave the input ready.
// A convert holds the input through its steps: map, address, store read, products, sums;
// its result is registered at the sums step, one item at a time.
// The result register holds while out_ready is low; the last step waits on it.
// Reset clears control and loads register defaults; the stores are not cleared.
`timescale 1ns / 1ps

module nv12_to_rgb_nearest_scaler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nvrs_pkg::PADDR_W-1:0]  paddr,
    input  logic [nvrs_pkg::PDATA_W-1:0]  pwdata,
    output logic [nvrs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [nvrs_pkg::KIND_W-1:0]   kind,
    input  logic [nvrs_pkg::ADDR_W-1:0]   store_address,
    input  logic [nvrs_pkg::BYTE_W-1:0]   store_value,
    input  logic [nvrs_pkg::DEST_W-1:0]   dest_x,
    input  logic [nvrs_pkg::DEST_W-1:0]   dest_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [nvrs_pkg::BYTE_W-1:0]   red,
    output logic [nvrs_pkg::BYTE_W-1:0]   green,
    output logic [nvrs_pkg::BYTE_W-1:0]   blue
);

    nvrs_pkg::cfg_t cfg;
    nvrs_pkg::cmd_t cmd;

    nvrs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nvrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    nvrs_datapath u_datapath (
        .clk           (clk),
        .cmd           (cmd),
        .cfg           (cfg),
        .store_address (store_address),
        .store_value   (store_value),
        .dest_x        (dest_x),
        .dest_y        (dest_y),
        .red           (red),
        .green         (green),
        .blue          (blue)
    );

endmodule

// ===== rtl/nvrs_checker.sv =====
// Port-level checks for the scaler, bound to the top level.
// Depends on nvrs_pkg and nv12_to_rgb_nearest_scaler.
`timescale 1ns / 1ps

module nvrs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [nvrs_pkg::KIND_W-1:0]   kind,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [nvrs_pkg::BYTE_W-1:0]   red,
    input logic [nvrs_pkg::BYTE_W-1:0]   green,
    input logic [nvrs_pkg::BYTE_W-1:0]   blue
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue))
        else $error("result changed before transfer");

    a_busy_after_convert: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == nvrs_pkg::KIND_CONVERT) |=> !in_ready)
        else $error("input ready right after a convert transfer");

    a_busy_only_on_convert: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid && (kind == nvrs_pkg::KIND_CONVERT)))
        else $error("input ready dropped without a convert transfer");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a convert in flight");

    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
        else $error("convert finished without a result");

endmodule

bind nv12_to_rgb_nearest_scaler nvrs_checker u_nvrs_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking testbench for nv12_to_rgb_nearest_scaler: APB register access, directed
// and random NV12 store writes and pixel conversions, each result checked against a
// built-in nearest-neighbor BT.601 predictor. Depends on nvrs_pkg and the scaler RTL.

module tb_top;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int REG_COUNT      = 5;
    localparam int PHASE_ITEMS    = 250;
    localparam int PHASE_COUNT    = 8;

    localparam logic [nvrs_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [25:0] STEP_UNITY = 26'd65536;
    localparam logic [25:0] STEP_MAX   = 26'h3FFFFFF;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [nvrs_pkg::PADDR_W-1:0]   paddr;
    logic [nvrs_pkg::PDATA_W-1:0]   pwdata;
    logic [nvrs_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_ready;
    logic [nvrs_pkg::KIND_W-1:0]    kind;
    logic [nvrs_pkg::ADDR_W-1:0]    store_address;
    logic [nvrs_pkg::BYTE_W-1:0]    store_value;
    logic [nvrs_pkg::DEST_W-1:0]    dest_x;
    logic [nvrs_pkg::DEST_W-1:0]    dest_y;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [nvrs_pkg::BYTE_W-1:0]    red;
    logic [nvrs_pkg::BYTE_W-1:0]    green;
    logic [nvrs_pkg::BYTE_W-1:0]    blue;

    nvrs_pkg::cfg_t     shadow_cfg;
    logic [7:0]         luma_shadow [int unsigned];
    logic [7:0]         chroma_shadow [int unsigned];
    rgb_t               expected_pixels [$];
    int                 error_count = 0;
    int                 items_sent = 0;
    int                 quiet_cycles = 0;
    bit                 idle_enable = 1'b1;

    nv12_to_rgb_nearest_scaler DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .store_address (store_address),
        .store_value   (store_value),
        .dest_x        (dest_x),
        .dest_y        (dest_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red           (red),
        .green         (green),
        .blue          (blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [9:0] map_coord(input logic [9:0] d, input logic [25:0] step,
                                             input logic [10:0] size);
        logic [10:0] lim;
        logic [10:0] bound;
        logic [63:0] scaled;
        lim = (size > 11'(nvrs_pkg::MAX_DIM)) ? 11'(nvrs_pkg::MAX_DIM) : size;
        bound = (lim == 11'd0) ? 11'd0 : lim - 11'd1;
        scaled = (64'(d) * 64'(step)) >> 16;
        return (scaled > 64'(bound)) ? bound[9:0] : scaled[9:0];
    endfunction

    function automatic void fetch_addresses(input logic [9:0] dx, input logic [9:0] dy,
                                            output int unsigned luma_idx,
                                            output int unsigned cb_idx,
                                            output int unsigned cr_idx);
        logic [9:0]  sx;
        logic [9:0]  sy;
        logic [63:0] luma_lin;
        logic [63:0] chroma_lin;
        sx = map_coord(dx, shadow_cfg.x_step, shadow_cfg.src_width);
        sy = map_coord(dy, shadow_cfg.y_step, shadow_cfg.src_height);
        luma_lin = 64'(sy) * 64'(shadow_cfg.line_stride) + 64'(sx);
        chroma_lin = 64'(sy >> 1) * 64'({shadow_cfg.line_stride[10:1], 1'b0})
                   + 64'(sx >> 1) * 64'd2;
        luma_idx = int'(luma_lin % 64'(nvrs_pkg::LUMA_WORDS));
        cb_idx = int'(chroma_lin % 64'(nvrs_pkg::CHROMA_WORDS));
        cr_idx = int'((chroma_lin + 64'd1) % 64'(nvrs_pkg::CHROMA_WORDS));
    endfunction

    function automatic logic [7:0] clamp_channel(input int sum);
        int q;
        if (sum < 0)
            return 8'd0;
        q = sum >>> 10;
        return (q > 255) ? 8'd255 : 8'(q);
    endfunction

    function automatic rgb_t convert_yuv(input logic [7:0] yb, input logic [7:0] ub,
                                         input logic [7:0] vb);
        int   y;
        int   u;
        int   v;
        int   yy;
        rgb_t px;
        y = int'(yb) - 16;
        u = int'(ub) - 128;
        v = int'(vb) - 128;
        yy = 1192 * y;
        px.red = clamp_channel(yy + 1634 * v);
        px.green = clamp_channel(yy - 833 * v - 400 * u);
        px.blue = clamp_channel(yy + 2066 * u);
        return px;
    endfunction

    function automatic logic [31:0] register_value(input logic [2:0] index);
        case (index)
            nvrs_pkg::REG_SRC_WIDTH:   return 32'(shadow_cfg.src_width);
            nvrs_pkg::REG_SRC_HEIGHT:  return 32'(shadow_cfg.src_height);
            nvrs_pkg::REG_LINE_STRIDE: return 32'(shadow_cfg.line_stride);
            nvrs_pkg::REG_X_STEP:      return 32'(shadow_cfg.x_step);
            nvrs_pkg::REG_Y_STEP:      return 32'(shadow_cfg.y_step);
            default:                   return 32'd0;
        endcase
    endfunction

    task automatic check_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (index)
            nvrs_pkg::REG_SRC_WIDTH:   shadow_cfg.src_width = data[10:0];
            nvrs_pkg::REG_SRC_HEIGHT:  shadow_cfg.src_height = data[10:0];
            nvrs_pkg::REG_LINE_STRIDE: shadow_cfg.line_stride = data[10:0];
            nvrs_pkg::REG_X_STEP:      shadow_cfg.x_step = data[25:0];
            nvrs_pkg::REG_Y_STEP:      shadow_cfg.y_step = data[25:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic check_registers;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= {3'(i), 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            if (prdata !== register_value(3'(i)))
            begin
                $display("%0t: register %0d mismatch, expected %0d actual %0d",
                         $time, i, register_value(3'(i)), prdata);
                error_count++;
            end
            psel <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_idle;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [10:0] w, input logic [10:0] h,
                              input logic [10:0] stride, input logic [25:0] xs,
                              input logic [25:0] ys);
        wait_idle();
        write_register(nvrs_pkg::REG_SRC_WIDTH, {21'($urandom), w});
        write_register(nvrs_pkg::REG_SRC_HEIGHT, {21'($urandom), h});
        write_register(nvrs_pkg::REG_LINE_STRIDE, {21'($urandom), stride});
        write_register(nvrs_pkg::REG_X_STEP, {6'($urandom), xs});
        write_register(nvrs_pkg::REG_Y_STEP, {6'($urandom), ys});
    endtask

    task automatic send_item(input logic [1:0] item_kind, input logic [19:0] addr,
                             input logic [7:0] value, input logic [9:0] dx,
                             input logic [9:0] dy);
        int unsigned li;
        int unsigned ci;
        int unsigned vi;
        while (idle_enable && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= item_kind;
        store_address <= addr;
        store_value <= value;
        dest_x <= dx;
        dest_y <= dy;
        do @(posedge clk); while (!in_ready);
        case (item_kind)
            nvrs_pkg::KIND_LUMA:
            begin
                luma_shadow[addr] = value;
            end
            nvrs_pkg::KIND_CHROMA:
            begin
                if (addr < nvrs_pkg::CHROMA_WORDS)
                    chroma_shadow[addr] = value;
            end
            nvrs_pkg::KIND_CONVERT:
            begin
                fetch_addresses(dx, dy, li, ci, vi);
                expected_pixels.push_back(convert_yuv(luma_shadow[li], chroma_shadow[ci],
                                                      chroma_shadow[vi]));
            end
            default: ;
        endcase
        items_sent++;
    endtask

    // Fill any source byte not yet written, then convert.
    task automatic convert_pixel(input logic [9:0] dx, input logic [9:0] dy);
        int unsigned li;
        int unsigned ci;
        int unsigned vi;
        fetch_addresses(dx, dy, li, ci, vi);
        if (!luma_shadow.exists(li))
            send_item(nvrs_pkg::KIND_LUMA, 20'(li), 8'($urandom), 10'($urandom),
                      10'($urandom));
        if (!chroma_shadow.exists(ci))
            send_item(nvrs_pkg::KIND_CHROMA, 20'(ci), 8'($urandom), 10'($urandom),
                      10'($urandom));
        if (!chroma_shadow.exists(vi))
            send_item(nvrs_pkg::KIND_CHROMA, 20'(vi), 8'($urandom), 10'($urandom),
                      10'($urandom));
        send_item(nvrs_pkg::KIND_CONVERT, 20'($urandom), 8'($urandom), dx, dy);
    endtask

    task automatic paint_pixel(input logic [9:0] dx, input logic [9:0] dy,
                               input logic [7:0] yv, input logic [7:0] uv,
                               input logic [7:0] vv);
        int unsigned li;
        int unsigned ci;
        int unsigned vi;
        fetch_addresses(dx, dy, li, ci, vi);
        send_item(nvrs_pkg::KIND_LUMA, 20'(li), yv, dx, dy);
        send_item(nvrs_pkg::KIND_CHROMA, 20'(ci), uv, dx, dy);
        send_item(nvrs_pkg::KIND_CHROMA, 20'(vi), vv, dx, dy);
        send_item(nvrs_pkg::KIND_CONVERT, 20'(li), yv, dx, dy);
    endtask

    task automatic test_register_access;
        check_registers();
        for (int i = 0; i < REG_COUNT; i++)
            write_register(3'(i), $urandom);
        check_registers();
        for (int i = REG_COUNT; i < 8; i++)
            write_register(3'(i), $urandom);
        check_registers();
    endtask

    task automatic test_color_extremes;
        set_config(11'd4, 11'd4, 11'd4, STEP_UNITY, STEP_UNITY);
        paint_pixel(10'd0, 10'd0, 8'd0, 8'd0, 8'd0);
        paint_pixel(10'd0, 10'd0, 8'd255, 8'd255, 8'd255);
        paint_pixel(10'd3, 10'd3, 8'd16, 8'd128, 8'd128);
    endtask

    task automatic test_clamp_and_wrap;
        // zero size: bound collapses to the first row and column
        set_config(11'd0, 11'd0, 11'd1, STEP_MAX, STEP_MAX);
        convert_pixel(10'd1023, 10'd1023);
        // oversize bounds, odd stride, both fetch addresses wrap
        set_config(11'd2047, 11'd2047, 11'd2047, STEP_MAX, STEP_MAX);
        convert_pixel(10'd1023, 10'd1023);
        set_config(11'd1024, 11'd1024, 11'd1024, 26'd0, STEP_UNITY);
        convert_pixel(10'd1023, 10'd1023);
    endtask

    task automatic test_ignored_items;
        set_config(11'd4, 11'd4, 11'd4, STEP_UNITY, STEP_UNITY);
        send_item(KIND_UNUSED, 20'($urandom), 8'($urandom), 10'($urandom), 10'($urandom));
        send_item(nvrs_pkg::KIND_CHROMA, 20'h80000, 8'h5A, 10'd0, 10'd0);
        send_item(nvrs_pkg::KIND_CHROMA, 20'hFFFFF, 8'hA5, 10'd0, 10'd0);
        convert_pixel(10'd0, 10'd0);
    endtask

    task automatic random_item;
        int          pick;
        logic [9:0]  dx;
        logic [9:0]  dy;
        pick = $urandom_range(99);
        dx = $urandom_range(1) ? 10'($urandom) : 10'($urandom_range(63));
        dy = $urandom_range(1) ? 10'($urandom) : 10'($urandom_range(63));
        if (pick < 65)
            convert_pixel(dx, dy);
        else if (pick < 80)
            send_item(nvrs_pkg::KIND_LUMA, 20'($urandom), 8'($urandom), 10'($urandom),
                      10'($urandom));
        else if (pick < 95)
            send_item(nvrs_pkg::KIND_CHROMA, 20'($urandom), 8'($urandom), 10'($urandom),
                      10'($urandom));
        else
            send_item(KIND_UNUSED, 20'($urandom), 8'($urandom), 10'($urandom),
                      10'($urandom));
    endtask

    task automatic test_random_traffic;
        int          phase_end;
        logic [10:0] w;
        logic [10:0] h;
        logic [10:0] stride;
        logic [25:0] xs;
        logic [25:0] ys;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: set_config(11'd720, 11'd480, 11'd720, 26'd73728, 26'd49152);
                1: set_config(11'd1, 11'd1, 11'd1, 26'd0, 26'd0);
                2: set_config(11'd2047, 11'd2047, 11'd2047, STEP_MAX, STEP_MAX);
                default:
                begin
                    w = $urandom_range(3) == 0 ? 11'($urandom) : 11'($urandom_range(1, 96));
                    h = $urandom_range(3) == 0 ? 11'($urandom) : 11'($urandom_range(1, 96));
                    stride = $urandom_range(3) == 0 ? 11'($urandom) : w;
                    xs = $urandom_range(3) == 0 ? 26'($urandom) : 26'($urandom_range(262144));
                    ys = $urandom_range(3) == 0 ? 26'($urandom) : 26'($urandom_range(262144));
                    set_config(w, h, stride, xs, ys);
                end
            endcase
            idle_enable = (phase != 3);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                random_item();
        end
        idle_enable = 1'b1;
    endtask

    always @(posedge clk)
        out_ready <= !(idle_enable && $urandom_range(99) < 9);

    always @(posedge clk)
    begin : result_check
        rgb_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none actual %0d %0d %0d",
                         $time, red, green, blue);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_channel("red", want.red, red);
                check_channel("green", want.green, green);
                check_channel("blue", want.blue, blue);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        kind <= '0;
        store_address <= '0;
        store_value <= '0;
        dest_x <= '0;
        dest_y <= '0;
        shadow_cfg.src_width = 11'd720;
        shadow_cfg.src_height = 11'd480;
        shadow_cfg.line_stride = 11'd720;
        shadow_cfg.x_step = 26'd73728;
        shadow_cfg.y_step = 26'd49152;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_color_extremes();
        test_clamp_and_wrap();
        test_ignored_items();
        test_random_traffic();
        wait_idle();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
